// ----- rtl/core/qsu_pkg.sv -----
// Package for the quoted string unescaper: phase and status codes, result type.
// No dependencies; imported by quoted_string_unescape.
package qsu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_OCT  = 3'd3,
    PH_HEX  = 3'd4,
    PH_DONE = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_UNQUOTED    = 3'd2,
    ST_PREM_ESC    = 3'd3,
    ST_INVALID_ESC = 3'd4,
    ST_PREM_END    = 3'd5
  } status_e;

  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  localparam int unsigned OctDigitsMax = 3;
  localparam int unsigned HexDigitsMax = 2;

  // One result item.
  typedef struct packed {
    logic [15:0] consumed;
    logic [2:0]  status;
    logic        last;
    logic [7:0]  out_byte;
  } result_t;

  function automatic result_t mk_data(input logic [7:0] b);
    result_t r;
    r.consumed = '0;
    r.status   = ST_OK;
    r.last     = 1'b0;
    r.out_byte = b;
    return r;
  endfunction

  function automatic result_t mk_status(input status_e st, input logic [15:0] cnt);
    result_t r;
    r.consumed = cnt;
    r.status   = st;
    r.last     = 1'b1;
    r.out_byte = '0;
    return r;
  endfunction

endpackage

// ----- rtl/core/quoted_string_unescape.sv -----
// Quoted string unescaper, top level: decode logic, state registers, result queue.
// Depends on qsu_pkg.
//
// Takes one source character per request on the slave stream and decodes a single- or
// double-quoted string literal with C-style escapes (\" \' \b \f \n \r \t \\,
// backslash-newline, up to three octal digits, \x with up to two hex digits). Data bytes
// leave on the master stream with tlast low; each string ends with one status request
// (tlast high) carrying the status code and the count of consumed characters, quotes
// included, saturating at 65535; an end item counts only when it cuts a string short,
// and empty or unquoted input reports zero. An end item is a slave request with tlast
// high (its tdata is ignored). After a status, characters are dropped until the end
// item. Throughput is one character per cycle: decode is a single combinational pass
// from the state registers and the accepted character into a 4-entry result queue.
// One character yields at most two results, so tready is held low while the queue holds
// more than two; with the master side always ready the queue never fills that far.
module quoted_string_unescape
  import qsu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  logic        s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] out_byte, [10:8] status, [26:11] consumed
  output logic        m_axis_tlast_o    // last
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  // Decoder state
  phase_e      phase_q, phase_d;
  logic        quote_dbl_q, quote_dbl_d;
  logic [8:0]  esc_val_q, esc_val_d;
  logic [1:0]  dig_cnt_q, dig_cnt_d;
  logic [15:0] pos_q, pos_d;

  // Result queue
  result_t           q_mem [QDepth];
  logic [QAw-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QAw:0]      cnt_q;

  logic        in_acc, out_acc;
  logic [7:0]  c;
  logic        eot;
  logic [1:0]  n_res;
  result_t     res0, res1;

  // Helpers for the decode pass
  logic [15:0] pos_inc;
  logic [7:0]  quote_ch;
  logic        is_oct, is_hex;
  logic [3:0]  hex_val;
  logic [1:0]  dig_nxt;
  logic [8:0]  oct_acc, hex_acc;

  assign c   = s_axis_tdata_i;
  assign eot = s_axis_tlast_i;

  assign s_axis_tready_o = (cnt_q <= (QAw+1)'(QDepth - 2));
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign out_acc         = m_axis_tvalid_o & m_axis_tready_i;

  assign pos_inc  = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
  assign quote_ch = quote_dbl_q ? CH_DQUOTE : CH_SQUOTE;
  assign is_oct   = (c inside {[8'h30:8'h37]});
  assign dig_nxt  = dig_cnt_q + 2'd1;
  assign oct_acc  = {esc_val_q[5:0], c[2:0]};
  assign hex_acc  = {esc_val_q[4:0], hex_val};

  always_comb begin
    is_hex  = 1'b1;
    hex_val = '0;
    if (c inside {[8'h30:8'h39]}) begin
      hex_val = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      hex_val = c[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  // Single decode pass. The body-character path is shared by the body phase and by a
  // numeric escape that a non-digit ends (which first emits the escape byte).
  always_comb begin
    logic body_path;
    phase_d     = phase_q;
    quote_dbl_d = quote_dbl_q;
    esc_val_d   = esc_val_q;
    dig_cnt_d   = dig_cnt_q;
    pos_d       = pos_q;
    n_res       = 2'd0;
    res0        = mk_data(8'h00);
    res1        = mk_data(8'h00);
    body_path   = 1'b0;

    case (phase_q)
      PH_DONE: begin
        if (eot) phase_d = PH_IDLE;
      end
      PH_BODY, PH_ESC, PH_OCT, PH_HEX: begin
        if (eot) begin
          phase_d = PH_IDLE;
          pos_d   = pos_inc;
          if (phase_q == PH_OCT || phase_q == PH_HEX) begin
            res0  = mk_data(esc_val_q[7:0]);
            res1  = mk_status(ST_PREM_END, pos_inc);
            n_res = 2'd2;
          end else begin
            res0  = mk_status((phase_q == PH_ESC) ? ST_PREM_ESC : ST_PREM_END, pos_inc);
            n_res = 2'd1;
          end
        end else begin
          case (phase_q)
            PH_OCT: begin
              if (is_oct) begin
                pos_d     = pos_inc;
                esc_val_d = oct_acc;
                dig_cnt_d = dig_nxt;
                if (dig_nxt >= 2'(OctDigitsMax)) begin
                  phase_d = PH_BODY;
                  res0    = mk_data(oct_acc[7:0]);
                  n_res   = 2'd1;
                end
              end else begin
                res0      = mk_data(esc_val_q[7:0]);
                n_res     = 2'd1;
                phase_d   = PH_BODY;
                body_path = 1'b1;
              end
            end
            PH_HEX: begin
              if (is_hex) begin
                pos_d     = pos_inc;
                esc_val_d = hex_acc;
                dig_cnt_d = dig_nxt;
                if (dig_nxt >= 2'(HexDigitsMax)) begin
                  phase_d = PH_BODY;
                  res0    = mk_data(hex_acc[7:0]);
                  n_res   = 2'd1;
                end
              end else begin
                res0      = mk_data(esc_val_q[7:0]);
                n_res     = 2'd1;
                phase_d   = PH_BODY;
                body_path = 1'b1;
              end
            end
            PH_ESC: begin
              pos_d   = pos_inc;
              phase_d = PH_BODY;
              n_res   = 2'd1;
              case (c)
                CH_DQUOTE, CH_SQUOTE, CH_BACKSLASH: res0 = mk_data(c);
                8'h62: res0 = mk_data(8'h08);   // \b
                8'h66: res0 = mk_data(8'h0C);   // \f
                8'h6E: res0 = mk_data(8'h0A);   // \n
                8'h72: res0 = mk_data(8'h0D);   // \r
                8'h74: res0 = mk_data(8'h09);   // \t
                CH_NEWLINE: n_res = 2'd0;       // line continuation
                8'h78, 8'h58: begin             // \x, \X
                  n_res     = 2'd0;
                  esc_val_d = '0;
                  dig_cnt_d = '0;
                  phase_d   = PH_HEX;
                end
                default: begin
                  if (is_oct) begin
                    n_res     = 2'd0;
                    esc_val_d = {6'd0, c[2:0]};
                    dig_cnt_d = 2'd1;
                    phase_d   = PH_OCT;
                  end else begin
                    phase_d = PH_DONE;
                    res0    = mk_status(ST_INVALID_ESC, pos_inc);
                  end
                end
              endcase
            end
            default: begin
              body_path = 1'b1;
            end
          endcase

          if (body_path) begin
            pos_d = pos_inc;
            if (c == CH_BACKSLASH) begin
              phase_d = PH_ESC;
            end else begin
              if (c == quote_ch) phase_d = PH_DONE;
              if (n_res == 2'd0) begin
                res0 = (c == quote_ch) ? mk_status(ST_OK, pos_inc) : mk_data(c);
              end else begin
                res1 = (c == quote_ch) ? mk_status(ST_OK, pos_inc) : mk_data(c);
              end
              n_res = n_res + 2'd1;
            end
          end
        end
      end
      default: begin
        // idle: expect the opening quote
        phase_d = PH_IDLE;
        n_res   = 2'd1;
        if (eot) begin
          res0 = mk_status(ST_EMPTY, 16'd0);
        end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
          n_res       = 2'd0;
          quote_dbl_d = (c == CH_DQUOTE);
          pos_d       = 16'd1;
          phase_d     = PH_BODY;
        end else begin
          phase_d = PH_DONE;
          res0    = mk_status(ST_UNQUOTED, 16'd0);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      quote_dbl_q <= 1'b0;
      esc_val_q   <= '0;
      dig_cnt_q   <= '0;
      pos_q       <= '0;
    end else if (in_acc) begin
      phase_q     <= phase_d;
      quote_dbl_q <= quote_dbl_d;
      esc_val_q   <= esc_val_d;
      dig_cnt_q   <= dig_cnt_d;
      pos_q       <= pos_d;
    end
  end

  // Queue pointers and fill level
  logic [QAw:0] n_push;
  assign n_push = in_acc ? (QAw+1)'(n_res) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + n_push[QAw-1:0];
      if (out_acc) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + n_push - (QAw+1)'(out_acc);
    end
  end

  // Queue payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc && n_res != 2'd0) q_mem[wr_ptr_q] <= res0;
    if (in_acc && n_res == 2'd2) q_mem[wr_ptr_q + 1'b1] <= res1;
  end

  result_t head;
  assign head           = q_mem[rd_ptr_q];
  assign m_axis_tdata_o = {5'd0, head.consumed, head.status, head.out_byte};
  assign m_axis_tlast_o = head.last;

endmodule

// ----- tb/quoted_string_unescape_tb.sv -----
// Self-checking testbench for quoted_string_unescape: directed table, then random
// strings checked against a local decoder model.
// Depends on qsu_pkg and quoted_string_unescape.
`timescale 1ns / 1ps

module quoted_string_unescape_tb;
  import qsu_pkg::*;

  localparam int unsigned RandomItems = 1400;

  // One directed row; typed rows carry the status request expected for that character.
  typedef struct packed {
    logic [7:0]  ch;
    logic        eot;
    logic        typed;
    status_e     st;
    logic [15:0] cnt;
  } dir_row_t;

  localparam dir_row_t DIRECTED [29] = '{
    '{8'h00, 1'b1, 1'b1, ST_EMPTY,       16'd0},  // end item while idle
    '{8'h00, 1'b0, 1'b1, ST_UNQUOTED,    16'd0},  // byte zero as opening
    '{8'hA5, 1'b1, 1'b0, ST_OK,          16'd0},
    '{8'h27, 1'b0, 1'b0, ST_OK,          16'd0},  // single-quoted string
    '{8'h22, 1'b0, 1'b0, ST_OK,          16'd0},  // other quote is plain
    '{8'hFF, 1'b0, 1'b0, ST_OK,          16'd0},
    '{8'h5C, 1'b0, 1'b0, ST_OK,          16'd0},
    '{8'h0A, 1'b0, 1'b0, ST_OK,          16'd0},  // line continuation
    '{8'h5C, 1'b0, 1'b0, ST_OK,          16'd0},
    '{8'h37, 1'b0, 1'b0, ST_OK,          16'd0},
    '{8'h37, 1'b0, 1'b0, ST_OK,          16'd0},
    '{8'h37, 1'b0, 1'b0, ST_OK,          16'd0},  // octal 777 keeps low byte
    '{8'h5C, 1'b0, 1'b0, ST_OK,          16'd0},
    '{8'h58, 1'b0, 1'b0, ST_OK,          16'd0},  // \X without digits
    '{8'h27, 1'b0, 1'b0, ST_OK,          16'd0},  // flushes 0, then closes
    '{8'h00, 1'b1, 1'b0, ST_OK,          16'd0},
    '{8'h22, 1'b0, 1'b0, ST_OK,          16'd0},
    '{8'h5C, 1'b0, 1'b0, ST_OK,          16'd0},
    '{8'h71, 1'b0, 1'b1, ST_INVALID_ESC, 16'd3},  // \q
    '{8'h00, 1'b1, 1'b0, ST_OK,          16'd0},
    '{8'h22, 1'b0, 1'b0, ST_OK,          16'd0},
    '{8'h5C, 1'b0, 1'b0, ST_OK,          16'd0},
    '{8'hFF, 1'b1, 1'b1, ST_PREM_ESC,    16'd3},  // end right after backslash
    '{8'h22, 1'b0, 1'b0, ST_OK,          16'd0},
    '{8'h5C, 1'b0, 1'b0, ST_OK,          16'd0},
    '{8'h31, 1'b0, 1'b0, ST_OK,          16'd0},
    '{8'h00, 1'b1, 1'b0, ST_OK,          16'd0},  // pending octal, then premature end
    '{8'h22, 1'b0, 1'b0, ST_OK,          16'd0},
    '{8'h00, 1'b1, 1'b1, ST_PREM_END,    16'd2}
  };

  localparam logic [7:0] SIMPLE_ESC [9] = '{CH_DQUOTE, CH_SQUOTE, CH_BACKSLASH, "b", "f",
                                            "n", "r", "t", CH_NEWLINE};

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] ch
  logic        s_axis_tlast_i;   // end_of_text
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // [7:0] out_byte, [10:8] status, [26:11] consumed
  logic        m_axis_tlast_o;   // last

  quoted_string_unescape dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Decoder state mirrored by the testbench.
  phase_e      ph      = PH_IDLE;
  logic        dq      = 1'b0;
  logic [8:0]  esc_val = '0;
  logic [1:0]  ndig    = '0;
  logic [15:0] pos     = '0;

  result_t     char_results [$];   // results of the character just taken
  result_t     decoded_queue [$];  // results still owed by the DUT
  logic        typed_use = 1'b0;
  result_t     typed_res = '0;
  logic        tx_burst  = 1'b0;
  logic        rx_burst  = 1'b0;
  int unsigned stim_count = 0;
  int unsigned errors     = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void push_data(input logic [7:0] b);
    result_t r;
    r = '0;
    r.out_byte = b;
    char_results.push_back(r);
  endfunction

  function automatic void push_status(input status_e st, input logic [15:0] cnt);
    result_t r;
    r = '0;
    r.last     = 1'b1;
    r.status   = st;
    r.consumed = cnt;
    char_results.push_back(r);
  endfunction

  function automatic void bump_pos();
    if (pos != 16'hFFFF) pos = pos + 16'd1;
  endfunction

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  // Advance the mirrored decoder by one accepted character; results go to char_results.
  function automatic void unescape_char(input logic [7:0] c, input logic eot);
    logic [7:0] q;
    int         hv;
    char_results.delete();
    if (ph == PH_DONE) begin
      if (eot) ph = PH_IDLE;
      return;
    end
    if (ph == PH_IDLE) begin
      if (eot) begin
        push_status(ST_EMPTY, 16'd0);
      end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
        dq  = (c == CH_DQUOTE);
        pos = 16'd1;
        ph  = PH_BODY;
      end else begin
        push_status(ST_UNQUOTED, 16'd0);
        ph = PH_DONE;
      end
      return;
    end
    if (eot) begin
      // A pending numeric escape is flushed before the status.
      if (ph == PH_OCT || ph == PH_HEX) push_data(esc_val[7:0]);
      bump_pos();
      push_status((ph == PH_ESC) ? ST_PREM_ESC : ST_PREM_END, pos);
      ph = PH_IDLE;
      return;
    end
    hv = hex_value(c);
    if (ph == PH_OCT) begin
      if (c >= "0" && c <= "7") begin
        bump_pos();
        esc_val = {esc_val[5:0], c[2:0]};
        ndig    = ndig + 2'd1;
        if (ndig >= OctDigitsMax) begin
          ph = PH_BODY;
          push_data(esc_val[7:0]);
        end
        return;
      end
      push_data(esc_val[7:0]);
      ph = PH_BODY;
    end else if (ph == PH_HEX) begin
      if (hv >= 0) begin
        bump_pos();
        esc_val = {esc_val[4:0], hv[3:0]};
        ndig    = ndig + 2'd1;
        if (ndig >= HexDigitsMax) begin
          ph = PH_BODY;
          push_data(esc_val[7:0]);
        end
        return;
      end
      push_data(esc_val[7:0]);
      ph = PH_BODY;
    end else if (ph == PH_ESC) begin
      bump_pos();
      ph = PH_BODY;
      case (c)
        CH_DQUOTE, CH_SQUOTE, CH_BACKSLASH: push_data(c);
        "b":        push_data(8'h08);
        "f":        push_data(8'h0C);
        "n":        push_data(8'h0A);
        "r":        push_data(8'h0D);
        "t":        push_data(8'h09);
        CH_NEWLINE: ;
        "x", "X": begin
          esc_val = '0;
          ndig    = '0;
          ph      = PH_HEX;
        end
        default: begin
          if (c >= "0" && c <= "7") begin
            esc_val = {6'd0, c[2:0]};
            ndig    = 2'd1;
            ph      = PH_OCT;
          end else begin
            ph = PH_DONE;
            push_status(ST_INVALID_ESC, pos);
          end
        end
      endcase
      return;
    end
    // body character, also the one that ended a numeric escape
    bump_pos();
    q = dq ? CH_DQUOTE : CH_SQUOTE;
    if (c == CH_BACKSLASH) begin
      ph = PH_ESC;
    end else if (c == q) begin
      ph = PH_DONE;
      push_status(ST_OK, pos);
    end else begin
      push_data(c);
    end
  endfunction

  // Predict on every accepted request, check every delivered one.
  always @(posedge clk_i) begin : scoreboard
    result_t want;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      unescape_char(s_axis_tdata_i, s_axis_tlast_i);
      if (typed_use) decoded_queue.push_back(typed_res);
      else foreach (char_results[i]) decoded_queue.push_back(char_results[i]);
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (decoded_queue.size() == 0) begin
        $error("result with nothing pending: tdata %0h tlast %0b",
               m_axis_tdata_o, m_axis_tlast_o);
        errors++;
      end else begin
        want = decoded_queue.pop_front();
        if (m_axis_tdata_o[7:0] !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, m_axis_tdata_o[7:0]);
          errors++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast_o);
          errors++;
        end
        if (m_axis_tdata_o[10:8] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata_o[10:8]);
          errors++;
        end
        if (m_axis_tdata_o[26:11] !== want.consumed) begin
          $error("consumed: expected %0d, got %0d", want.consumed, m_axis_tdata_o[26:11]);
          errors++;
        end
      end
    end
  end

  // Receiver: random stall before each request unless in a burst stretch.
  initial begin : rx_side
    int unsigned stall;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      stall = rx_burst ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Called and returns at a falling edge; tvalid stays high until the next call's gap or the caller lowers it.
  task automatic send(input logic [7:0] c, input logic eot, input logic typed = 1'b0,
                      input status_e st = ST_OK, input logic [15:0] cnt = 16'd0);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    if (ph != PH_DONE) stim_count++;
    typed_use = typed;
    typed_res = '0;
    typed_res.last     = 1'b1;
    typed_res.status   = st;
    typed_res.consumed = cnt;
    s_axis_tdata_i  <= c;
    s_axis_tlast_i  <= eot;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (decoded_queue.size() != 0) @(negedge clk_i);
  endtask

  // One string: mostly well formed with random content, some noise and broken endings.
  task automatic send_random_string();
    logic [7:0]  q;
    logic [7:0]  c;
    int unsigned kind;
    int unsigned d;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      send(8'($urandom), 1'b1);
      return;
    end
    if (kind == 1) begin
      send(8'($urandom), 1'b0);
      repeat ($urandom_range(0, 3)) send(8'($urandom), 1'b0);
      send(8'($urandom), 1'b1);
      return;
    end
    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
    send(q, 1'b0);
    repeat ($urandom_range(0, 10)) begin
      kind = $urandom_range(0, 15);
      case (kind)
        0, 1, 2, 3, 4, 5: send(8'($urandom), 1'b0);
        6, 7: begin
          send(CH_BACKSLASH, 1'b0);
          send(SIMPLE_ESC[$urandom_range(0, 8)], 1'b0);
        end
        8, 9: begin
          send(CH_BACKSLASH, 1'b0);
          repeat ($urandom_range(1, 3)) send(8'("0" + $urandom_range(0, 7)), 1'b0);
        end
        10, 11: begin
          send(CH_BACKSLASH, 1'b0);
          send($urandom_range(0, 1) ? "x" : "X", 1'b0);
          repeat ($urandom_range(0, 2)) begin
            d = $urandom_range(0, 15);
            if (d < 10) c = 8'("0" + d);
            else c = 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
            send(c, 1'b0);
          end
        end
        12: begin
          send(CH_BACKSLASH, 1'b0);
          send(8'($urandom), 1'b0);
        end
        13: send((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE, 1'b0);
        default: send(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
      endcase
    end
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      send(q, 1'b0);
      repeat ($urandom_range(0, 2)) send(8'($urandom), 1'b0);  // dropped after the status
    end else if (kind == 7) begin
      send(CH_BACKSLASH, 1'b0);
    end
    send(8'($urandom), 1'b1);
  endtask

  initial begin : stimulus
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[i])
      send(DIRECTED[i].ch, DIRECTED[i].eot, DIRECTED[i].typed, DIRECTED[i].st,
           DIRECTED[i].cnt);

    // Hold off until the DUT has delivered everything.
    s_axis_tvalid_i <= 1'b0;
    wait_drained();

    stim_count = 0;
    while (stim_count < RandomItems) begin
      tx_burst = ($urandom_range(0, 7) == 0);
      rx_burst = ($urandom_range(0, 7) == 0);
      send_random_string();
    end

    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    repeat (10) @(negedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
